@@ rtl/rtg_pkg.sv @@
// ----------------------------------------------------------------------------
// rtg_pkg: shared types and constants for the grouped text converter
// Field widths, character codes and the controller/datapath command set.
// ----------------------------------------------------------------------------
package rtg_pkg;

	localparam int NUM_W   = 64;
	localparam int RADIX_W = 6;
	localparam int CHAR_W  = 7;
	localparam int CNT_W   = 7;
	localparam int REM_W   = 5;
	localparam int BIT_CNT_W = $clog2(NUM_W);
	localparam int GROUP   = 5;

	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(26);

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(8'h30);
	localparam logic [CHAR_W-1:0] ASCII_A     = CHAR_W'(8'h41);
	localparam logic [CHAR_W-1:0] ASCII_SPACE = CHAR_W'(8'h20);
	localparam logic [REM_W-1:0]  DEC_LIMIT   = REM_W'(10);

	typedef logic [NUM_W-1:0]   num_t;
	typedef logic [RADIX_W-1:0] radix_t;
	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic wr_digit;
		logic rd_char;
		logic next_char;
	} rtg_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic radix_ok;
		logic div_last;
		logic quo_zero;
		logic emit_last;
	} rtg_stat_t;

	// Map a digit value to its ASCII character
	function automatic char_t digit_char(input logic [REM_W-1:0] d);
		char_t c;
		if (d < DEC_LIMIT) begin
			c = ASCII_ZERO + CHAR_W'(d);
		end else begin
			c = ASCII_A + CHAR_W'(d - DEC_LIMIT);
		end
		return c;
	endfunction

endpackage

@@ rtl/rtg_if.sv @@
// ----------------------------------------------------------------------------
// rtg_if: channel interfaces of the grouped text converter
// Request channel carries a value and base; result channel one character.
// ----------------------------------------------------------------------------
interface rtg_item_if;
	logic            valid;
	logic            ready;
	rtg_pkg::num_t   number_in;
	rtg_pkg::radix_t radix;

	modport source (output valid, output number_in, output radix, input ready);
	modport sink   (input valid, input number_in, input radix, output ready);
endinterface

interface rtg_result_if;
	logic           valid;
	logic           ready;
	rtg_pkg::char_t text_char;
	logic           last_char;
	rtg_pkg::cnt_t  digit_count;
	logic           bad_radix;
	logic           overflowed;

	modport source (output valid, output text_char, output last_char, output digit_count,
		output bad_radix, output overflowed, input ready);
	modport sink   (input valid, input text_char, input last_char, input digit_count,
		input bad_radix, input overflowed, output ready);
endinterface

@@ rtl/rtg_datapath.sv @@
// ----------------------------------------------------------------------------
// rtg_datapath: divider, line memory and character output register
// Bit-serial restoring division by the base, digit placement with group
// spacing, and registered readout of the line one character at a time.
// ----------------------------------------------------------------------------
module rtg_datapath #(
	parameter int LINE_BUFFER_LEN = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rtg_pkg::rtg_cmd_t  cmd,
	input  rtg_pkg::num_t      number_in,
	input  rtg_pkg::radix_t    radix,
	output rtg_pkg::rtg_stat_t stat,
	output rtg_pkg::char_t     text_char,
	output logic               last_char,
	output rtg_pkg::cnt_t      digit_count,
	output logic               bad_radix,
	output logic               overflowed
);
	import rtg_pkg::*;

	localparam int LINE_LEN = LINE_BUFFER_LEN - 1;
	localparam int PW       = $clog2(LINE_BUFFER_LEN);
	localparam logic [PW-1:0] LINE_TOP  = PW'(LINE_LEN);
	localparam logic [PW-1:0] LINE_LAST = PW'(LINE_LEN - 1);
	localparam logic [2:0]    LINE_MOD  = 3'(LINE_LEN % GROUP);
	localparam logic [2:0]    MOD_TOP   = 3'(GROUP - 1);
	localparam logic [2:0]    SKIP_MOD  = 3'(GROUP - 2);

	num_t                 quo_q;
	logic [REM_W-1:0]     rem_q;
	logic [REM_W-1:0]     radix_q;
	logic [BIT_CNT_W-1:0] bit_q;
	logic [PW-1:0]        free_q;
	logic [2:0]           free_mod_q;
	cnt_t                 digits_q;
	logic                 ovf_q;
	logic                 err_q;
	logic [PW-1:0]        emit_q;
	logic [2:0]           emit_mod_q;
	char_t                rd_q;
	logic                 space_q;
	logic                 pad_q;

	char_t                line_mem [LINE_LEN];

	logic [REM_W:0]       trial;
	logic                 fits;
	logic [REM_W-1:0]     rem_next;
	logic                 skip_space;
	logic [PW-1:0]        wr_addr;
	logic                 radix_ok;

	// Check the base against the supported range
	always_comb begin
		radix_ok = radix inside {[RADIX_MIN:RADIX_MAX]};
	end

	// One restoring division step: bring down the next quotient bit
	always_comb begin
		trial    = {rem_q, quo_q[NUM_W-1]};
		fits     = trial >= {1'b0, radix_q};
		rem_next = fits ? REM_W'(trial - {1'b0, radix_q}) : REM_W'(trial);
	end

	// Place the next digit left of any group space
	always_comb begin
		skip_space = (free_q != '0) && (free_mod_q == '0);
		wr_addr    = skip_space ? (free_q - PW'(2)) : (free_q - PW'(1));
	end

	// Advance division, digit placement and readout counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q      <= '0;
			free_q     <= '0;
			free_mod_q <= '0;
			digits_q   <= '0;
			ovf_q      <= 1'b0;
			err_q      <= 1'b0;
			emit_q     <= '0;
			emit_mod_q <= '0;
		end else begin
			if (cmd.load) begin
				bit_q      <= '0;
				free_q     <= LINE_TOP;
				free_mod_q <= LINE_MOD;
				digits_q   <= '0;
				ovf_q      <= 1'b0;
				err_q      <= !radix_ok;
				emit_q     <= '0;
				emit_mod_q <= 3'd1;
			end
			if (cmd.div_step) begin
				bit_q <= bit_q + BIT_CNT_W'(1);
			end
			if (cmd.wr_digit) begin
				digits_q <= digits_q + CNT_W'(1);
				if (free_q == '0) begin
					ovf_q <= 1'b1;
				end else if (skip_space) begin
					free_q     <= free_q - PW'(2);
					free_mod_q <= SKIP_MOD;
				end else begin
					free_q     <= free_q - PW'(1);
					free_mod_q <= free_mod_q - 3'd1;
				end
			end
			if (cmd.next_char) begin
				emit_q     <= emit_q + PW'(1);
				emit_mod_q <= (emit_mod_q == MOD_TOP) ? 3'd0 : emit_mod_q + 3'd1;
			end
		end
	end

	// Hold the running quotient and remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q   <= '0;
			rem_q   <= '0;
			radix_q <= '0;
		end else if (cmd.load) begin
			quo_q   <= number_in;
			rem_q   <= '0;
			radix_q <= REM_W'(radix);
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= rem_next;
		end else if (cmd.wr_digit) begin
			rem_q <= '0;
		end
	end

	// Write the finished digit into the line
	always_ff @(posedge clk) begin
		if (cmd.wr_digit && (free_q != '0)) begin
			line_mem[wr_addr] <= digit_char(rem_q);
		end
	end

	// Read the next character with its space and pad marks
	always_ff @(posedge clk) begin
		if (cmd.rd_char) begin
			rd_q    <= line_mem[emit_q];
			space_q <= (emit_mod_q == '0);
			pad_q   <= (emit_q < free_q);
		end
	end

	assign stat.radix_ok  = radix_ok;
	assign stat.div_last  = (bit_q == '1);
	assign stat.quo_zero  = (quo_q == '0);
	assign stat.emit_last = (emit_q == LINE_LAST);

	// Select the shown character
	always_comb begin
		if (err_q) begin
			text_char = '0;
		end else if (space_q) begin
			text_char = ASCII_SPACE;
		end else if (pad_q) begin
			text_char = ASCII_ZERO;
		end else begin
			text_char = rd_q;
		end
	end

	assign last_char   = err_q || (emit_q == LINE_LAST);
	assign digit_count = err_q ? '0 : digits_q;
	assign bad_radix   = err_q;
	assign overflowed  = !err_q && ovf_q;

	// Digits go into the line only after a full 64-bit pass
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_digit |-> (bit_q == '0))
		else $error("digit written mid-division");

endmodule

@@ rtl/rtg_ctrl.sv @@
// ----------------------------------------------------------------------------
// rtg_ctrl: sequencing controller for the grouped text converter
// Steps the datapath through division, digit placement and readout.
// ----------------------------------------------------------------------------
module rtg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  rtg_pkg::rtg_stat_t stat,
	output rtg_pkg::rtg_cmd_t  cmd
);
	import rtg_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIV   = 6'b000010,
		ST_WRITE = 6'b000100,
		ST_READ  = 6'b001000,
		ST_SHOW  = 6'b010000,
		ST_ERR   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_SHOW) || (state_q == ST_ERR);

	// Decode next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = stat.radix_ok ? ST_DIV : ST_ERR;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.wr_digit = 1'b1;
				state_d      = stat.quo_zero ? ST_READ : ST_DIV;
			end
			ST_READ: begin
				cmd.rd_char = 1'b1;
				state_d     = ST_SHOW;
			end
			ST_SHOW: begin
				if (out_ready) begin
					if (stat.emit_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.next_char = 1'b1;
						state_d       = ST_READ;
					end
				end
			end
			ST_ERR: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("request taken while a result is shown");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !stat.radix_ok) |=> (out_valid && state_q == ST_ERR))
		else $error("bad base did not give an error result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHOW && out_ready && stat.emit_last) |=> in_ready)
		else $error("no return to idle after last character");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_digit && !stat.quo_zero) |=> (state_q == ST_DIV))
		else $error("division stopped with quotient left");

endmodule

@@ rtl/radix_to_grouped_text.sv @@
// ----------------------------------------------------------------------------
// radix_to_grouped_text: integer to grouped text line converter
// Converts a 64-bit value in base 2..26 into a right-aligned line with a
// space every fifth position and zero padding, emitted one character each.
// ----------------------------------------------------------------------------
//  channel   role    payload
//  item      sink    number_in[63:0], radix[5:0]
//  result    source  text_char[6:0], last_char, digit_count[6:0],
//                    bad_radix, overflowed
//
//  Each digit takes 64 steps of the bit-serial divider and one line
//  memory write. Each character is read out through the registered memory
//  port in a READ state and then shown in a SHOW state, which holds it
//  until the result channel takes it.
//  A bad base gives one error result in the cycle after the request is taken.
//  One request is in flight at a time; the next is taken after the last
//  character is delivered. Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module radix_to_grouped_text #(
	parameter int LINE_BUFFER_LEN = 64
) (
	input logic          clk,
	input logic          arst_n,
	rtg_item_if.sink     item,
	rtg_result_if.source result
);
	import rtg_pkg::*;

	rtg_cmd_t  cmd;
	rtg_stat_t stat;

	rtg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rtg_datapath #(
		.LINE_BUFFER_LEN (LINE_BUFFER_LEN)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.number_in   (item.number_in),
		.radix       (item.radix),
		.stat        (stat),
		.text_char   (result.text_char),
		.last_char   (result.last_char),
		.digit_count (result.digit_count),
		.bad_radix   (result.bad_radix),
		.overflowed  (result.overflowed)
	);

endmodule
